// ===== rtl/core/asdg_pkg.sv =====
// ----------------------------------------------------------------------------
// asdg_pkg
// Shared types, constants and the arctangent step table of the arc step
// delay generator.
// ----------------------------------------------------------------------------
`default_nettype none

package asdg_pkg;

  localparam int TIME_BITS = 32;
  localparam int DELAY_W   = TIME_BITS + 2;

  localparam logic [63:0] TIME_MAX  = (64'd1 << TIME_BITS) - 64'd1;
  localparam logic [31:0] PI_Q30    = 32'd3373259426;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [60:0] ONE_Q60   = 61'h1000_0000_0000_0000;
  localparam logic signed [63:0] DELAY_MAX = 64'sd2147483647;
  localparam logic signed [63:0] DELAY_MIN = -64'sd2147483648;

  localparam logic [31:0] RADIUS_RST = 32'd1000000;
  localparam logic [19:0] STEP_RST   = 20'd1000;
  localparam logic [31:0] KTIME_RST  = 32'd1000000;

  typedef enum logic [1:0] {
    CMD_X    = 2'd0,
    CMD_Y    = 2'd1,
    CMD_ARM  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_STEP_X = 2'd1,
    REG_STEP_Y = 2'd2,
    REG_KTIME  = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MULP,
    ST_SETUP,
    ST_DIV,
    ST_SQ,
    ST_SQGO,
    ST_SQRT,
    ST_CGO,
    ST_CORD,
    ST_TMUL,
    ST_TSAT,
    ST_DONE
  } state_t;

  // atan(2^-i) in q2.30, halving exactly past i = 10
  function automatic logic [30:0] atan_step(input logic [4:0] i);
    logic [30:0] a;
    unique case (i)
      5'd0:    a = 31'd843314857;
      5'd1:    a = 31'd497837829;
      5'd2:    a = 31'd263043837;
      5'd3:    a = 31'd133525159;
      5'd4:    a = 31'd67021687;
      5'd5:    a = 31'd33543516;
      5'd6:    a = 31'd16775851;
      5'd7:    a = 31'd8388437;
      5'd8:    a = 31'd4194283;
      5'd9:    a = 31'd2097149;
      5'd10:   a = 31'd1048576;
      default: a = 31'd1 << (5'd30 - i);
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/asdg_if.sv =====
// ----------------------------------------------------------------------------
// asdg_in_if / asdg_out_if
// Valid/ready channels for step requests and step delay results.
// ----------------------------------------------------------------------------
`default_nettype none

interface asdg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [23:0] step_index;
  logic [23:0] start_index_y;

  modport source (output valid, cmd, step_index, start_index_y, input ready);
  modport sink   (input valid, cmd, step_index, start_index_y, output ready);
endinterface

interface asdg_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         axis;
  logic signed [31:0] delay_us;
  logic               clamped;

  modport source (output valid, axis, delay_us, clamped, input ready);
  modport sink   (input valid, axis, delay_us, clamped, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/asdg_div.sv =====
// ----------------------------------------------------------------------------
// asdg_div
// Restoring divider, one quotient bit per cycle: floor(num * 2^30 / den)
// for num <= den.
// ----------------------------------------------------------------------------
`default_nettype none

module asdg_div import asdg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] num,
  input  wire logic [31:0] den,
  output logic             done,
  output logic [30:0]      quo
);

  logic [32:0] rem_r;
  logic [31:0] den_r;
  logic [30:0] quo_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic        ge;
  logic [32:0] diff;

  assign ge   = rem_r >= {1'b0, den_r};
  assign diff = rem_r - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd30) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num};
      den_r <= den;
    end else if (busy_r) begin
      // bring down the next zero bit of num * 2^30
      rem_r <= (ge ? diff : rem_r) << 1;
      quo_r <= {quo_r[29:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

// ===== rtl/core/asdg_sqrt.sv =====
// ----------------------------------------------------------------------------
// asdg_sqrt
// Bit-pair integer square root of a 61-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module asdg_sqrt import asdg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [60:0] val,
  output logic             done,
  output logic [30:0]      root
);

  logic [60:0] v_r;
  logic [60:0] res_r;
  logic [60:0] bit_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [60:0] trial;
  logic        ge;

  assign trial = res_r + bit_r;
  assign ge    = v_r >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd30) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= val;
      res_r <= '0;
      bit_r <= ONE_Q60;
    end else if (busy_r) begin
      v_r   <= ge ? v_r - trial : v_r;
      res_r <= ge ? (res_r >> 1) + bit_r : res_r >> 1;
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[30:0];

endmodule

`default_nettype wire

// ===== rtl/core/asdg_cordic.sv =====
// ----------------------------------------------------------------------------
// asdg_cordic
// Vectoring cordic, 31 iterations, one per cycle: atan2(y0, x0) in q2.30
// radians for non-negative inputs, negative angles end as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module asdg_cordic import asdg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [30:0] x0,
  input  wire logic [30:0] y0,
  output logic             done,
  output logic [31:0]      angle
);

  logic signed [33:0] xv_r;
  logic signed [33:0] yv_r;
  logic signed [33:0] z_r;
  logic [4:0]         cnt_r;
  logic               busy_r;
  logic               done_r;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] a;

  assign xs = xv_r >>> cnt_r;
  assign ys = yv_r >>> cnt_r;
  assign a  = signed'({3'b000, atan_step(cnt_r)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd30) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xv_r <= signed'({3'b000, x0});
      yv_r <= signed'({3'b000, y0});
      z_r  <= '0;
    end else if (busy_r) begin
      if (!yv_r[33]) begin
        xv_r <= xv_r + ys;
        yv_r <= yv_r - xs;
        z_r  <= z_r + a;
      end else begin
        xv_r <= xv_r - ys;
        yv_r <= yv_r + xs;
        z_r  <= z_r - a;
      end
    end
  end

  assign done  = done_r;
  assign angle = z_r[33] ? 32'd0 : z_r[31:0];

endmodule

`default_nettype wire

// ===== rtl/core/arc_step_delay_generator.sv =====
// ----------------------------------------------------------------------------
// arc_step_delay_generator
// Per-axis step delays for motion along a circular arc.
// ----------------------------------------------------------------------------
// One request at a time: an x or y step runs one axis, an arm request runs
// both axes in turn, and unused command 3 goes straight to the result. Each
// axis runs three iterative units one after another: the ratio divider, the
// complement square root and the cordic arctangent, with sequencer states
// around one shared 32x32 multiplier. A clamped ratio skips the divider. A
// finished result waits in the output register and the next request is taken
// once that result has been placed there.
`default_nettype none

module arc_step_delay_generator import asdg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  asdg_in_if.sink          in_chan,
  asdg_out_if.source       out_chan,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  state_t state_r, state_nxt;

  logic [31:0] radius_r, ktime_r;
  logic [19:0] step_x_r, step_y_r;

  logic [TIME_BITS-1:0] prev_x_r, prev_y_r, off_x_r, off_y_r;
  logic [TIME_BITS-1:0] tx_r, ty_r;

  cmd_t        cmd_r;
  logic [23:0] n_r, ny_r;
  logic        axis_y_r;
  logic        neg_r;
  logic        flag_r;
  logic [30:0] qm_r;
  logic [30:0] w_r;
  logic [31:0] angle_r;
  logic [63:0] mul_r;
  logic [31:0] mul_a, mul_b;

  logic        out_valid_r;
  logic [1:0]  out_axis_r;
  logic [31:0] out_delay_r;
  logic        out_clamped_r;

  logic        div_start, div_done;
  logic [31:0] div_num;
  logic [30:0] div_quo;
  logic        sqrt_start, sqrt_done;
  logic [30:0] sqrt_root;
  logic        cord_start, cord_done;
  logic [31:0] cord_angle;
  logic [30:0] cord_x, cord_y;

  logic        in_fire, out_free;
  logic [23:0] idx_sel;
  logic [19:0] step_sel;
  logic [31:0] r_eff;
  logic [44:0] p, r45, r2_45;
  logic        clamp_now;
  logic [44:0] num45;
  logic [63:0] t64;
  logic [TIME_BITS-1:0] t_sat;
  logic signed [DELAY_W-1:0] d_x, d_y;
  logic signed [63:0] d_sel;
  logic [31:0] d_out;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      step_x_r <= STEP_RST;
      step_y_r <= STEP_RST;
      ktime_r  <= KTIME_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_RADIUS: radius_r <= cfg_data;
        REG_STEP_X: step_x_r <= cfg_data[19:0];
        REG_STEP_Y: step_y_r <= cfg_data[19:0];
        REG_KTIME:  ktime_r  <= cfg_data;
      endcase
    end
  end

  // ---- operand selection ----
  assign idx_sel  = (axis_y_r && cmd_r == CMD_ARM) ? ny_r : n_r;
  assign step_sel = axis_y_r ? step_y_r : step_x_r;
  assign r_eff    = (radius_r == 32'd0) ? 32'd1 : radius_r;
  assign p        = mul_r[44:0];
  assign r45      = {13'b0, r_eff};
  assign r2_45    = {12'b0, r_eff, 1'b0};
  assign clamp_now = axis_y_r ? (p > r45) : (p > r2_45);
  assign num45    = axis_y_r ? p : ((p <= r45) ? r45 - p : p - r45);
  assign div_num  = num45[31:0];

  // atan2(w, |q|) for x, atan2(q, w) for y
  assign cord_x = axis_y_r ? w_r : qm_r;
  assign cord_y = axis_y_r ? qm_r : w_r;

  assign t64   = {30'b0, mul_r[63:30]};
  assign t_sat = (t64 > TIME_MAX) ? TIME_MAX[TIME_BITS-1:0] : t64[TIME_BITS-1:0];

  assign d_x = signed'({2'b00, tx_r}) - signed'({2'b00, prev_x_r})
             + signed'({2'b00, off_x_r});
  assign d_y = signed'({2'b00, ty_r}) - signed'({2'b00, prev_y_r})
             + signed'({2'b00, off_y_r});
  assign d_sel = 64'(axis_y_r ? d_y : d_x);
  assign d_out = (d_sel > DELAY_MAX) ? DELAY_MAX[31:0] :
                 (d_sel < DELAY_MIN) ? DELAY_MIN[31:0] : d_sel[31:0];

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    cord_start = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (cmd_t'(in_chan.cmd) == CMD_NONE) ? ST_DONE : ST_MULP;
        end
      end
      ST_MULP: begin
        mul_a     = {12'b0, step_sel};
        mul_b     = {7'b0, {1'b0, idx_sel} + 25'd1};
        state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        if (clamp_now) begin
          state_nxt = ST_SQ;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_SQ;
      end
      ST_SQ: begin
        mul_a     = {1'b0, qm_r};
        mul_b     = {1'b0, qm_r};
        state_nxt = ST_SQGO;
      end
      ST_SQGO: begin
        sqrt_start = 1'b1;
        state_nxt  = ST_SQRT;
      end
      ST_SQRT: begin
        if (sqrt_done) state_nxt = ST_CGO;
      end
      ST_CGO: begin
        cord_start = 1'b1;
        state_nxt  = ST_CORD;
      end
      ST_CORD: begin
        if (cord_done) state_nxt = ST_TMUL;
      end
      ST_TMUL: begin
        mul_a     = ktime_r;
        mul_b     = angle_r;
        state_nxt = ST_TSAT;
      end
      ST_TSAT: begin
        state_nxt = (!axis_y_r && cmd_r == CMD_ARM) ? ST_MULP : ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // shared multiplier, one registered product per cycle
  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  // ---- datapath registers ----
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r    <= cmd_t'(in_chan.cmd);
      n_r      <= in_chan.step_index;
      ny_r     <= in_chan.start_index_y;
      axis_y_r <= (cmd_t'(in_chan.cmd) == CMD_Y);
      flag_r   <= 1'b0;
    end
    if (state_r == ST_SETUP) begin
      neg_r <= !axis_y_r && (p > r45);
      if (clamp_now) begin
        qm_r   <= ONE_Q30;
        flag_r <= 1'b1;
      end
    end
    if (state_r == ST_DIV && div_done) begin
      qm_r <= div_quo;
      // a negative ratio that truncates to zero counts as zero
      if (div_quo == '0) neg_r <= 1'b0;
    end
    if (state_r == ST_SQRT && sqrt_done) w_r <= sqrt_root;
    if (state_r == ST_CORD && cord_done) begin
      angle_r <= neg_r ? PI_Q30 - cord_angle : cord_angle;
    end
    if (state_r == ST_TSAT) begin
      if (axis_y_r) begin
        ty_r <= t_sat;
      end else begin
        tx_r <= t_sat;
        if (cmd_r == CMD_ARM) axis_y_r <= 1'b1;
      end
    end
  end

  // ---- axis state and result register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      off_x_r     <= '0;
      off_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_chan.ready) out_valid_r <= 1'b0;
      if (state_r == ST_DONE && out_free) begin
        out_valid_r   <= 1'b1;
        out_axis_r    <= cmd_r;
        out_delay_r   <= 32'd0;
        out_clamped_r <= 1'b0;
        priority case (cmd_r)
          CMD_X: begin
            out_delay_r   <= d_out;
            out_clamped_r <= flag_r;
            prev_x_r      <= tx_r;
            off_x_r       <= '0;
          end
          CMD_Y: begin
            out_delay_r   <= d_out;
            out_clamped_r <= flag_r;
            prev_y_r      <= ty_r;
            off_y_r       <= '0;
          end
          CMD_ARM: begin
            out_clamped_r <= flag_r;
            prev_x_r      <= tx_r;
            prev_y_r      <= ty_r;
            if (tx_r < ty_r) begin
              off_x_r <= '0;
              off_y_r <= ty_r - tx_r;
            end else begin
              off_x_r <= tx_r - ty_r;
              off_y_r <= '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.axis     = out_axis_r;
  assign out_chan.delay_us = out_delay_r;
  assign out_chan.clamped  = out_clamped_r;

  // ---- iterative units ----
  asdg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (r_eff),
    .done  (div_done),
    .quo   (div_quo)
  );

  asdg_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .val   (ONE_Q60 - mul_r[60:0]),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  asdg_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .x0    (cord_x),
    .y0    (cord_y),
    .done  (cord_done),
    .angle (cord_angle)
  );

  // ---- assertions ----
  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV) else $error("divider finished unattended");

  a_sqrt_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_done |-> state_r == ST_SQRT) else $error("square root finished unattended");

  a_cord_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    cord_done |-> state_r == ST_CORD) else $error("cordic finished unattended");

  a_one_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> (off_x_r == '0 || off_y_r == '0))
    else $error("both start offsets nonzero");

endmodule

`default_nettype wire
